### hw/rtl/fdsu_pkg.sv
// ----------------------------------------------------------------------------
// Forth data stack unit package
// Shared constants, operation and status codes, payload types and the
// command and status structs between the controller and the datapath.
// ----------------------------------------------------------------------------
package fdsu_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam int KIND_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int DEPTH_W  = 5;

    localparam logic [KIND_W-1:0] KIND_PUSH  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SWAP  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DUP   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DROP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ROT   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_OVER  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_DRAIN = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDER = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVER  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]        kind;
        logic signed [WORD_W-1:0] value;
    } cmd_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] word;
        logic [DEPTH_W-1:0]       depth;
        logic                     last;
    } rsp_item_t;

    // Stack addresses are offsets from the current entry count, or the
    // drain pointer.
    typedef enum logic [2:0] {
        ADDR_N          = 3'd0,
        ADDR_N1         = 3'd1,
        ADDR_N2         = 3'd2,
        ADDR_N3         = 3'd3,
        ADDR_DRAIN      = 3'd4,
        ADDR_DRAIN_NEXT = 3'd5
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_VALUE = 2'd0,
        WD_TOP   = 2'd1,
        WD_RD    = 2'd2,
        WD_TMP   = 2'd3
    } wd_sel_t;

    typedef enum logic [1:0] {
        TOP_HOLD  = 2'd0,
        TOP_VALUE = 2'd1,
        TOP_RD    = 2'd2,
        TOP_TMP   = 2'd3
    } top_sel_t;

    typedef enum logic [1:0] {
        CNT_HOLD  = 2'd0,
        CNT_INC   = 2'd1,
        CNT_DEC   = 2'd2,
        CNT_CLEAR = 2'd3
    } cnt_op_t;

    typedef struct packed {
        logic                op_load;
        logic                rd_en;
        addr_sel_t           rd_sel;
        logic                wr_en;
        addr_sel_t           wr_sel;
        wd_sel_t             wd_sel;
        top_sel_t            top_sel;
        logic                tmp_load;
        cnt_op_t             cnt_op;
        logic                drain_inc;
        logic                drain_clr;
        logic                out_load;
        logic                out_drain;
        logic [STATUS_W-1:0] out_status;
    } ctl_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              cnt_zero;
        logic              cnt_ge2;
        logic              cnt_ge3;
        logic              cnt_full;
        logic              out_free;
        logic              drain_last;
    } stat_t;

endpackage

### hw/rtl/fdsu_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data. The read
// data holds its value while no read is issued.
// ----------------------------------------------------------------------------
module fdsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/fdsu_datapath.sv
// ----------------------------------------------------------------------------
// Forth data stack datapath
// Holds the operation, entry count, a copy of the top entry, a scratch word,
// the drain pointer, the stack RAM and the result register.
// ----------------------------------------------------------------------------
module fdsu_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  fdsu_pkg::cmd_item_t cmd,
    input  fdsu_pkg::ctl_t      ctl,
    output fdsu_pkg::stat_t     stat,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output fdsu_pkg::rsp_item_t rsp
);
    import fdsu_pkg::*;

    logic [KIND_W-1:0]        kind_reg;
    logic signed [WORD_W-1:0] value_reg;
    logic [CNT_W-1:0]         count_reg,     count_next;
    logic [WORD_W-1:0]        top_reg,       top_next;
    logic [WORD_W-1:0]        tmp_reg;
    logic [ADDR_W-1:0]        drain_idx_reg, drain_idx_next;
    rsp_item_t                rsp_reg,       rsp_next;
    logic                     rsp_valid_reg, rsp_valid_next;

    logic [CNT_W-1:0]  rd_full;
    logic [CNT_W-1:0]  wr_full;
    logic [CNT_W-1:0]  count_m1;
    logic [WORD_W-1:0] wr_data;
    logic [WORD_W-1:0] rd_data;

    function automatic logic [CNT_W-1:0] addr_of(addr_sel_t sel, logic [CNT_W-1:0] n,
                                                 logic [ADDR_W-1:0] idx);
        logic [CNT_W-1:0] a;
        case (sel)
            ADDR_N:          a = n;
            ADDR_N1:         a = n - CNT_W'(1);
            ADDR_N2:         a = n - CNT_W'(2);
            ADDR_N3:         a = n - CNT_W'(3);
            ADDR_DRAIN:      a = CNT_W'(idx);
            ADDR_DRAIN_NEXT: a = CNT_W'(idx) + CNT_W'(1);
            default:         a = '0;
        endcase
        return a;
    endfunction

    assign count_m1 = count_reg - CNT_W'(1);
    assign rd_full  = addr_of(ctl.rd_sel, count_reg, drain_idx_reg);
    assign wr_full  = addr_of(ctl.wr_sel, count_reg, drain_idx_reg);

    always_comb
    begin
        case (ctl.wd_sel)
            WD_VALUE: wr_data = value_reg;
            WD_TOP:   wr_data = top_reg;
            WD_RD:    wr_data = rd_data;
            WD_TMP:   wr_data = tmp_reg;
            default:  wr_data = top_reg;
        endcase
    end

    fdsu_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (ctl.wr_en),
        .wr_addr (wr_full[ADDR_W-1:0]),
        .wr_data (wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_full[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        case (ctl.cnt_op)
            CNT_INC:   count_next = count_reg + CNT_W'(1);
            CNT_DEC:   count_next = count_m1;
            CNT_CLEAR: count_next = '0;
            default:   count_next = count_reg;
        endcase

        case (ctl.top_sel)
            TOP_VALUE: top_next = value_reg;
            TOP_RD:    top_next = rd_data;
            TOP_TMP:   top_next = tmp_reg;
            default:   top_next = top_reg;
        endcase

        if (ctl.drain_clr)
        begin
            drain_idx_next = '0;
        end
        else if (ctl.drain_inc)
        begin
            drain_idx_next = drain_idx_reg + ADDR_W'(1);
        end
        else
        begin
            drain_idx_next = drain_idx_reg;
        end
    end

    // Results of ordinary operations are built from the already updated
    // count and top; drained entries come straight from the RAM read data.
    always_comb
    begin
        rsp_next        = rsp_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        if (ctl.out_load)
        begin
            rsp_valid_next = 1'b1;
            rsp_next.status = ctl.out_status;
            if (ctl.out_drain)
            begin
                rsp_next.word  = rd_data;
                rsp_next.depth = DEPTH_W'(count_m1 - CNT_W'(drain_idx_reg));
                rsp_next.last  = stat.drain_last;
            end
            else
            begin
                rsp_next.word  = (count_reg == '0) ? '0 : top_reg;
                rsp_next.depth = DEPTH_W'(count_reg);
                rsp_next.last  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            drain_idx_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            drain_idx_reg <= drain_idx_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op_load)
        begin
            kind_reg  <= cmd.kind;
            value_reg <= cmd.value;
        end
        if (ctl.tmp_load)
        begin
            tmp_reg <= rd_data;
        end
        top_reg <= top_next;
        rsp_reg <= rsp_next;
    end

    assign stat.kind       = kind_reg;
    assign stat.cnt_zero   = (count_reg == '0);
    assign stat.cnt_ge2    = (count_reg >= CNT_W'(2));
    assign stat.cnt_ge3    = (count_reg >= CNT_W'(3));
    assign stat.cnt_full   = (count_reg >= CNT_W'(STACK_DEPTH));
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;
    assign stat.drain_last = (CNT_W'(drain_idx_reg) == count_m1);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("entry count above stack depth");

    a_write_in_range : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> wr_full < CNT_W'(STACK_DEPTH))
        else $error("stack write beyond the last entry");

    a_drain_below_count : assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.out_load && ctl.out_drain) |-> CNT_W'(drain_idx_reg) < count_reg)
        else $error("drained entry not below entry count");

endmodule

### hw/rtl/fdsu_ctrl.sv
// ----------------------------------------------------------------------------
// Forth data stack controller
// Sequences each operation as reads and writes on the stack RAM, which has one
// read and one write port, and decides the result status.
// ----------------------------------------------------------------------------
module fdsu_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  fdsu_pkg::stat_t stat,
    output fdsu_pkg::ctl_t  ctl
);
    import fdsu_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_DISPATCH = 8'b0000_0010,
        S_FETCH    = 8'b0000_0100,
        S_FETCH2   = 8'b0000_1000,
        S_STORE1   = 8'b0001_0000,
        S_STORE2   = 8'b0010_0000,
        S_REPORT   = 8'b0100_0000,
        S_DRAIN    = 8'b1000_0000
    } state_t;

    state_t              state_reg,  state_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                under;
    logic                grow;

    always_comb
    begin
        case (stat.kind)
            KIND_SWAP, KIND_OVER: under = !stat.cnt_ge2;
            KIND_DUP, KIND_DROP:  under = stat.cnt_zero;
            KIND_ROT:             under = !stat.cnt_ge3;
            default:              under = 1'b0;
        endcase
        grow = stat.kind inside {KIND_PUSH, KIND_DUP, KIND_OVER};
    end

    always_comb
    begin
        ctl         = '0;
        ctl.rd_sel  = ADDR_N;
        ctl.wr_sel  = ADDR_N;
        ctl.wd_sel  = WD_TOP;
        ctl.top_sel = TOP_HOLD;
        ctl.cnt_op  = CNT_HOLD;
        ctl.out_status = status_reg;
        state_next  = state_reg;
        status_next = status_reg;
        cmd_ready   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                cmd_ready   = 1'b1;
                ctl.op_load = cmd_valid;
                if (cmd_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end

            S_DISPATCH:
            begin
                status_next = ST_OK;
                state_next  = S_REPORT;
                if (stat.kind == KIND_DRAIN)
                begin
                    if (stat.cnt_zero)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctl.rd_en  = 1'b1;
                        ctl.rd_sel = ADDR_DRAIN;
                        state_next = S_DRAIN;
                    end
                end
                else if (under)
                begin
                    status_next = ST_UNDER;
                end
                else if (grow && stat.cnt_full)
                begin
                    status_next = ST_OVER;
                end
                else
                begin
                    case (stat.kind)
                        KIND_PUSH:
                        begin
                            ctl.wr_en   = 1'b1;
                            ctl.wd_sel  = WD_VALUE;
                            ctl.top_sel = TOP_VALUE;
                            ctl.cnt_op  = CNT_INC;
                        end
                        KIND_DUP:
                        begin
                            ctl.wr_en  = 1'b1;
                            ctl.cnt_op = CNT_INC;
                        end
                        KIND_SWAP, KIND_OVER:
                        begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = ADDR_N2;
                            state_next = S_FETCH;
                        end
                        KIND_DROP:
                        begin
                            // With a single entry there is no new top to fetch.
                            if (stat.cnt_ge2)
                            begin
                                ctl.rd_en  = 1'b1;
                                ctl.rd_sel = ADDR_N2;
                                state_next = S_FETCH;
                            end
                            else
                            begin
                                ctl.cnt_op = CNT_DEC;
                            end
                        end
                        KIND_ROT:
                        begin
                            ctl.rd_en  = 1'b1;
                            ctl.rd_sel = ADDR_N3;
                            state_next = S_FETCH;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_FETCH:
            begin
                state_next = S_REPORT;
                case (stat.kind)
                    KIND_SWAP:
                    begin
                        ctl.wr_en    = 1'b1;
                        ctl.wr_sel   = ADDR_N1;
                        ctl.wd_sel   = WD_RD;
                        ctl.tmp_load = 1'b1;
                        state_next   = S_STORE1;
                    end
                    KIND_OVER:
                    begin
                        ctl.wr_en   = 1'b1;
                        ctl.wd_sel  = WD_RD;
                        ctl.top_sel = TOP_RD;
                        ctl.cnt_op  = CNT_INC;
                    end
                    KIND_DROP:
                    begin
                        ctl.top_sel = TOP_RD;
                        ctl.cnt_op  = CNT_DEC;
                    end
                    KIND_ROT:
                    begin
                        ctl.tmp_load = 1'b1;
                        ctl.rd_en    = 1'b1;
                        ctl.rd_sel   = ADDR_N2;
                        state_next   = S_FETCH2;
                    end
                    default:
                    begin
                    end
                endcase
            end

            S_FETCH2:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = ADDR_N3;
                ctl.wd_sel = WD_RD;
                state_next = S_STORE1;
            end

            S_STORE1:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_sel = ADDR_N2;
                ctl.wd_sel = WD_TOP;
                if (stat.kind == KIND_ROT)
                begin
                    state_next = S_STORE2;
                end
                else
                begin
                    ctl.top_sel = TOP_TMP;
                    state_next  = S_REPORT;
                end
            end

            S_STORE2:
            begin
                ctl.wr_en   = 1'b1;
                ctl.wr_sel  = ADDR_N1;
                ctl.wd_sel  = WD_TMP;
                ctl.top_sel = TOP_TMP;
                state_next  = S_REPORT;
            end

            S_REPORT:
            begin
                if (stat.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            S_DRAIN:
            begin
                // The read data holds the entry at the drain pointer; the next
                // entry is fetched in the same cycle that this one is sent.
                if (stat.out_free)
                begin
                    ctl.out_load   = 1'b1;
                    ctl.out_drain  = 1'b1;
                    ctl.out_status = ST_OK;
                    if (stat.drain_last)
                    begin
                        ctl.cnt_op    = CNT_CLEAR;
                        ctl.drain_clr = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        ctl.drain_inc = 1'b1;
                        ctl.rd_en     = 1'b1;
                        ctl.rd_sel    = ADDR_DRAIN_NEXT;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    a_load_when_free : assert property (@(posedge clk) disable iff (!rst_n)
        ctl.out_load |-> stat.out_free)
        else $error("result register loaded while occupied");

    a_drain_has_entries : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DRAIN |-> !stat.cnt_zero)
        else $error("draining an empty stack");

endmodule

### hw/rtl/forth_data_stack_unit.sv
// ----------------------------------------------------------------------------
// Forth data stack unit
// Bounded stack of signed 32-bit words with push, swap, dup, drop, rot, over
// and drain operations.
// ----------------------------------------------------------------------------
// An operation is taken only while the unit is between operations, and its
// result sits in an output register, so the next request is accepted while
// that result waits. The stack lives in a RAM with one read and one write
// port, and each operation is a sequence of reads and writes on it: push and
// dup write once, a one-entry drop, kind 7 and any underflow or overflow touch
// no entry, over reads once and writes once, a deeper drop reads once, swap
// reads once and writes twice, and rot reads twice and writes three times. A
// drain delivers one entry per cycle while the consumer keeps up.
// Entries are never cleared: the entry count alone says what is valid.
module forth_data_stack_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  fdsu_pkg::cmd_item_t cmd,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output fdsu_pkg::rsp_item_t rsp
);
    import fdsu_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    fdsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    fdsu_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .ctl       (ctl),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Forth data stack unit testbench
// Drives stack operations into the unit and keeps a shadow copy of the stack
// that predicts every status and drain result. The sender issues requests in
// bursts with gaps between them, and the receiver stalls on a changing
// pattern. One long receiver hold-off and one full pause of the sender are
// included. Each result is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    import fdsu_pkg::*;

    // Kind 7 has no operation behind it; it only reports the current top.
    localparam logic [KIND_W-1:0] KIND_SPARE = 3'd7;

    localparam int RANDOM_TARGET = 370;
    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = 30;
    localparam int CYCLE_LIMIT   = 300000;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      cmd_valid = 1'b0;
    logic      cmd_ready;
    cmd_item_t cmd       = '0;
    logic      rsp_valid;
    logic      rsp_ready = 1'b0;
    rsp_item_t rsp;

    forth_data_stack_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    typedef struct {
        rsp_item_t res;
        longint    stamp;
    } due_item_t;

    class stack_shadow;
        logic signed [WORD_W-1:0] words [STACK_DEPTH];
        int unsigned              held;
        due_item_t                due_results [$];
        int                       errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        function int unsigned depth_now();
            return held;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function void queue_result(logic [STATUS_W-1:0] st, logic signed [WORD_W-1:0] w,
                                   int unsigned d, logic lst, longint stamp);
            due_item_t e;
            e.res.status = st;
            e.res.word   = w;
            e.res.depth  = d[DEPTH_W-1:0];
            e.res.last   = lst;
            e.stamp      = stamp;
            due_results.push_back(e);
        endfunction

        // Applies one accepted operation to the shadow stack and queues the
        // results it must produce.
        function void apply_op(cmd_item_t item, longint stamp);
            int unsigned              n;
            int unsigned              need;
            bit                       grow;
            logic [STATUS_W-1:0]      st;
            logic signed [WORD_W-1:0] t;
            n    = held;
            need = 0;
            grow = 1'b0;
            st   = ST_OK;
            if (item.kind == KIND_DRAIN) begin
                if (n == 0) begin
                    queue_result(ST_EMPTY, '0, 0, 1'b1, stamp);
                end
                else begin
                    for (int i = 0; i < n; i++) begin
                        queue_result(ST_OK, words[i], n - 1 - i, i == n - 1, stamp);
                    end
                    held = 0;
                end
                return;
            end
            case (item.kind)
                KIND_PUSH: grow = 1'b1;
                KIND_SWAP: need = 2;
                KIND_DUP:
                begin
                    need = 1;
                    grow = 1'b1;
                end
                KIND_DROP: need = 1;
                KIND_ROT:  need = 3;
                KIND_OVER:
                begin
                    need = 2;
                    grow = 1'b1;
                end
                default: ;
            endcase
            // Too few entries wins over a full stack.
            if (n < need) begin
                st = ST_UNDER;
            end
            else if (grow && n >= STACK_DEPTH) begin
                st = ST_OVER;
            end
            else begin
                case (item.kind)
                    KIND_PUSH:
                    begin
                        words[n] = item.value;
                        n++;
                    end
                    KIND_SWAP:
                    begin
                        t            = words[n - 1];
                        words[n - 1] = words[n - 2];
                        words[n - 2] = t;
                    end
                    KIND_DUP:
                    begin
                        words[n] = words[n - 1];
                        n++;
                    end
                    KIND_DROP: n--;
                    KIND_ROT:
                    begin
                        t            = words[n - 3];
                        words[n - 3] = words[n - 2];
                        words[n - 2] = words[n - 1];
                        words[n - 1] = t;
                    end
                    KIND_OVER:
                    begin
                        words[n] = words[n - 2];
                        n++;
                    end
                    default: ;
                endcase
                held = n;
            end
            queue_result(st, (n != 0) ? words[n - 1] : '0, n, 1'b1, stamp);
        endfunction

        task report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
            errors++;
            if (errors <= 200) begin
                $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
            end
        endtask

        // A prediction noted in the same time step cannot be matched, so the
        // outcome does not depend on which process ran first.
        task check_result(rsp_item_t got, longint stamp);
            due_item_t head;
            rsp_item_t want;
            if (due_results.size() == 0 || due_results[0].stamp >= stamp) begin
                report_mismatch("unexpected result word", got.word, '0);
            end
            else begin
                head = due_results.pop_front();
                want = head.res;
                if (got.status !== want.status) begin
                    report_mismatch("status", WORD_W'(got.status), WORD_W'(want.status));
                end
                if (got.word !== want.word) report_mismatch("word", got.word, want.word);
                if (got.depth !== want.depth) begin
                    report_mismatch("depth", WORD_W'(got.depth), WORD_W'(want.depth));
                end
                if (got.last !== want.last) begin
                    report_mismatch("last", WORD_W'(got.last), WORD_W'(want.last));
                end
            end
        endtask
    endclass

    stack_shadow shadow = new();

    int cycles      = 0;
    int sent        = 0;
    int burst_left  = 0;
    bit offering    = 1'b0;
    bit hold_req    = 1'b0;
    bit hold_issued = 1'b0;
    bit pause_done  = 1'b0;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL forth_data_stack_unit");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready) begin
            shadow.check_result(rsp, $time);
        end
    end

    // Receiver: the stall level is redrawn after a random stretch; a hold request
    // from the stimulus keeps ready low for a long stretch.
    initial
    begin
        int level;
        int slot;
        bit rdy;
        level = 0;
        slot  = 0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                rsp_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else begin
                if (slot == 0) begin
                    level = $urandom_range(0, 3);
                    slot  = $urandom_range(20, 80);
                end
                else begin
                    slot--;
                end
                case (level)
                    0: rdy = 1'b1;
                    1: rdy = ($urandom_range(0, 3) != 0);
                    2: rdy = ($urandom_range(0, 1) != 0);
                    default: rdy = ($urandom_range(0, 4) == 0);
                endcase
                rsp_ready <= rdy;
            end
        end
    end

    function automatic logic signed [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2: return '0;
            3: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Offers one request, holds it until accepted, then either continues the
    // burst or drops valid for a random gap.
    task automatic issue(logic [KIND_W-1:0] k, logic signed [WORD_W-1:0] v);
        cmd_item_t item;
        int        gap;
        item.kind  = k;
        item.value = v;
        cmd_valid <= 1'b1;
        cmd       <= item;
        offering   = 1'b1;
        do @(posedge clk); while (!cmd_ready);
        shadow.apply_op(item, $time);
        sent++;
        if (burst_left == 0) begin
            gap        = $urandom_range(1, 10);
            cmd_valid <= 1'b0;
            offering   = 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(0, 24);
        end
        else begin
            burst_left--;
        end
    endtask

    task automatic wait_idle();
        if (offering) begin
            cmd_valid <= 1'b0;
            offering   = 1'b0;
        end
        while (shadow.pending() != 0) @(posedge clk);
    endtask

    task automatic run_directed();
        issue(KIND_DRAIN, 32'sd5);
        issue(KIND_DROP, '0);
        issue(KIND_SWAP, '0);
        issue(KIND_DUP, '0);
        issue(KIND_ROT, '0);
        issue(KIND_OVER, '0);
        issue(KIND_SPARE, '1);
        issue(KIND_PUSH, 32'sh7FFF_FFFF);
        issue(KIND_SWAP, '0);
        issue(KIND_OVER, '0);
        issue(KIND_DUP, '0);
        issue(KIND_ROT, '0);
        issue(KIND_PUSH, 32'sh8000_0000);
        issue(KIND_SWAP, 32'sh1234_5678);
        issue(KIND_ROT, '0);
        issue(KIND_OVER, '0);
        issue(KIND_DROP, '0);
        issue(KIND_PUSH, '0);
        issue(KIND_PUSH, '1);
        issue(KIND_SPARE, 32'sh5A5A_A5A5);
        issue(KIND_DRAIN, '0);
        issue(KIND_PUSH, $urandom);
        issue(KIND_DROP, '0);
        issue(KIND_DRAIN, '0);
    endtask

    // Fills the stack, then issues one to four operations at full depth, which
    // may try to grow it past full, and most of the time drains all entries.
    task automatic run_fill();
        while (shadow.depth_now() < STACK_DEPTH) issue(KIND_PUSH, pick_value());
        repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 5))
                0: issue(KIND_PUSH, pick_value());
                1: issue(KIND_DUP, $urandom);
                2: issue(KIND_OVER, $urandom);
                3: issue(KIND_SWAP, $urandom);
                4: issue(KIND_ROT, $urandom);
                default: issue(KIND_SPARE, $urandom);
            endcase
        end
        if ($urandom_range(0, 3) != 0) issue(KIND_DRAIN, $urandom);
    endtask

    task automatic run_mixed(int len);
        int r;
        repeat (len) begin
            r = $urandom_range(0, 99);
            if (shadow.depth_now() < 3 && r < 50) issue(KIND_PUSH, pick_value());
            else if (r < 30) issue(KIND_PUSH, pick_value());
            else if (r < 42) issue(KIND_SWAP, $urandom);
            else if (r < 52) issue(KIND_DUP, $urandom);
            else if (r < 64) issue(KIND_DROP, $urandom);
            else if (r < 74) issue(KIND_ROT, $urandom);
            else if (r < 84) issue(KIND_OVER, $urandom);
            else if (r < 92) issue(KIND_DRAIN, $urandom);
            else if (r < 97) issue(KIND_PUSH, pick_value());
            else issue(KIND_SPARE, $urandom);
        end
    endtask

    task automatic run_noise(int len);
        repeat (len) issue(KIND_W'($urandom_range(0, 7)), $urandom);
    endtask

    initial
    begin
        int r;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        run_directed();
        while (sent < RANDOM_TARGET) begin
            if (!hold_issued && sent >= 120) begin
                hold_issued = 1'b1;
                hold_req    = 1'b1;
            end
            if (!pause_done && sent >= 260) begin
                pause_done = 1'b1;
                wait_idle();
            end
            r = $urandom_range(0, 99);
            if (r < 15) run_fill();
            else if (r < 82) run_mixed($urandom_range(5, 20));
            else run_noise($urandom_range(1, 6));
        end
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (shadow.errors == 0 && shadow.pending() == 0) begin
            $display("PASS forth_data_stack_unit");
        end
        else begin
            $display("FAIL forth_data_stack_unit");
        end
        $finish;
    end

endmodule
